[design/fqpe_pkg.sv]
// shared types and constants for the positional-edit fifo queue
package fqpe_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int POS_W           = 5;
   localparam int COUNT_OUT_W     = 5;
   localparam int DATA_W          = 32;

   localparam logic signed [DATA_W-1:0] POP_EMPTY_DATA = -32'sd1;

   typedef enum logic [2:0] {
      FUNC_PUSH   = 3'd0,
      FUNC_POP    = 3'd1,
      FUNC_DELETE = 3'd2,
      FUNC_INSERT = 3'd3,
      FUNC_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_LOAD   = 2'd1,
      CELL_PULL   = 2'd2,
      CELL_INSERT = 2'd3
   } cell_mode_type;

   typedef struct packed {
      func_type                 func;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      status_type               status;
      logic [COUNT_OUT_W-1:0]   entry_count;
      logic                     is_empty;
   } rsp_type;

endpackage

[design/fqpe_cell.sv]
// one storage cell of the queue row, takes from itself, a neighbor or the new value
module fqpe_cell #(
   parameter int QUEUE_DEPTH = fqpe_pkg::QUEUE_DEPTH_DEF,
   parameter int INDEX       = 0
) (
   input  logic                                      clock,
   input  fqpe_pkg::cell_mode_type                   cell_mode,
   input  logic [((($clog2(QUEUE_DEPTH + 1)) > fqpe_pkg::POS_W) ?
                  $clog2(QUEUE_DEPTH + 1) : fqpe_pkg::POS_W) - 1:0] cell_where,
   input  logic signed [fqpe_pkg::DATA_W-1:0]        new_value,
   input  logic signed [fqpe_pkg::DATA_W-1:0]        left_data,
   input  logic signed [fqpe_pkg::DATA_W-1:0]        right_data,
   output logic signed [fqpe_pkg::DATA_W-1:0]        cell_data
);
   import fqpe_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cell_mode)
         CELL_LOAD: begin
            if (MY_IDX == cell_where) data_in = new_value;
         end
         CELL_PULL: begin
            if (MY_IDX >= cell_where) data_in = right_data;
         end
         CELL_INSERT: begin
            if (MY_IDX > cell_where) data_in = left_data;
            else if (MY_IDX == cell_where) data_in = new_value;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

[design/fqpe_ctrl.sv]
// operation decode, occupancy count and registered result for the queue
module fqpe_ctrl #(
   parameter int QUEUE_DEPTH = fqpe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  fqpe_pkg::req_type                         req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output fqpe_pkg::rsp_type                         rsp_data,
   input  logic signed [fqpe_pkg::DATA_W-1:0]        head_data,
   output fqpe_pkg::cell_mode_type                   cell_mode,
   output logic [((($clog2(QUEUE_DEPTH + 1)) > fqpe_pkg::POS_W) ?
                  $clog2(QUEUE_DEPTH + 1) : fqpe_pkg::POS_W) - 1:0] cell_where
);
   import fqpe_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   logic                  accept;
   logic                  is_empty_now;
   logic                  is_full_now;
   logic                  pos_ok;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      count_ext;
   cell_mode_type         mode_dec;
   logic [CMP_W-1:0]      where_dec;
   logic [CNT_W-1:0]      count_dec;
   status_type            status_dec;
   logic signed [DATA_W-1:0] data_dec;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign pos_ext      = CMP_W'(req_data.position);
   assign count_ext    = CMP_W'(count_ff);
   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pos_ok       = (pos_ext != '0) && (pos_ext <= count_ext);

   always_comb begin
      mode_dec   = CELL_HOLD;
      where_dec  = '0;
      count_dec  = count_ff;
      status_dec = STATUS_OK;
      data_dec   = '0;
      unique case (req_data.func)
         FUNC_PUSH: begin
            if (is_full_now) begin
               status_dec = STATUS_FULL;
            end else begin
               mode_dec  = CELL_LOAD;
               where_dec = count_ext;
               count_dec = count_ff + CNT_W'(1);
            end
         end
         FUNC_POP: begin
            if (is_empty_now) begin
               status_dec = STATUS_EMPTY;
               data_dec   = POP_EMPTY_DATA;
            end else begin
               data_dec  = head_data;
               mode_dec  = CELL_PULL;
               where_dec = '0;
               count_dec = count_ff - CNT_W'(1);
            end
         end
         FUNC_DELETE: begin
            if (is_empty_now) begin
               status_dec = STATUS_EMPTY;
            end else if (!pos_ok) begin
               status_dec = STATUS_RANGE;
            end else begin
               mode_dec  = CELL_PULL;
               where_dec = pos_ext - CMP_W'(1);
               count_dec = count_ff - CNT_W'(1);
            end
         end
         FUNC_INSERT: begin
            if (is_empty_now) begin
               status_dec = STATUS_EMPTY;
            end else if (!pos_ok) begin
               status_dec = STATUS_RANGE;
            end else if (is_full_now) begin
               status_dec = STATUS_FULL;
            end else begin
               mode_dec  = CELL_INSERT;
               where_dec = pos_ext - CMP_W'(1);
               count_dec = count_ff + CNT_W'(1);
            end
         end
         FUNC_CLEAR: begin
            count_dec = '0;
         end
         default: begin
            count_dec = count_ff;
         end
      endcase
   end

   assign cell_mode  = accept ? mode_dec : CELL_HOLD;
   assign cell_where = where_dec;

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         count_in                = count_dec;
         rsp_valid_in            = 1'b1;
         rsp_data_in.data_out    = data_dec;
         rsp_data_in.status      = status_dec;
         rsp_data_in.entry_count = COUNT_OUT_W'(count_dec);
         rsp_data_in.is_empty    = (count_dec == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with no result held");

   a_empty_flag_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.is_empty == (count_ff == '0)))
      else $error("empty flag disagrees with occupancy");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.func == FUNC_POP && !is_empty_now)
         |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not lower occupancy");

   a_idle_holds_count: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("occupancy moved without an item");

endmodule

[design/fifo_queue_positional_edit.sv]
// top level of the positional-edit fifo queue: control plus a row of storage cells
// The queue holds up to QUEUE_DEPTH signed 32-bit entries in a row of cells, head in
// cell 0. Every item (push, pop, delete at position, insert before position, clear)
// gives one result in the cycle after it is taken, and a new item can be taken every
// cycle unless the input stalls; cells from the edit point on shift toward head or tail
// in the same cycle, so the number of entries moved never adds time. The input stalls
// only while a result sits in the output register and the result side stalls. Positions
// are 1-based and must lie in 1..count for both delete and insert; a pop on an empty
// queue returns -1 with status empty. The entry count on the result is its low 5 bits.
module fifo_queue_positional_edit #(
   parameter int QUEUE_DEPTH = fqpe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fqpe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fqpe_pkg::rsp_type rsp_data
);
   import fqpe_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   cell_mode_type            cell_mode;
   logic [CMP_W-1:0]         cell_where;
   logic signed [DATA_W-1:0] cell_data [QUEUE_DEPTH];

   fqpe_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .head_data  (cell_data[0]),
      .cell_mode  (cell_mode),
      .cell_where (cell_where)
   );

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_data;
      logic signed [DATA_W-1:0] right_data;

      if (i == 0) begin : g_head
         assign left_data = cell_data[i];
      end else begin : g_mid_left
         assign left_data = cell_data[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_data = cell_data[i];
      end else begin : g_mid_right
         assign right_data = cell_data[i+1];
      end

      fqpe_cell #(
         .QUEUE_DEPTH(QUEUE_DEPTH),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .cell_mode  (cell_mode),
         .cell_where (cell_where),
         .new_value  (req_data.value),
         .left_data  (left_data),
         .right_data (right_data),
         .cell_data  (cell_data[i])
      );
   end

endmodule
